FILE: hdl/tcpqa_pkg.sv
// Shared types, field widths and codes of the two-class priority queue.
package tcpqa_pkg;

   // Port field widths
   localparam int CMD_W    = 3;
   localparam int TICKET_W = 16;
   localparam int TIME_W   = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int AGE_W    = 16;

   localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd120;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ENQUEUE   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EMERGENCY = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_AGE       = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   // Per-cycle cell operations
   localparam int CELL_OP_W = 3;
   localparam logic [CELL_OP_W-1:0] CELL_HOLD    = 3'd0;
   localparam logic [CELL_OP_W-1:0] CELL_PUSH_HI = 3'd1;
   localparam logic [CELL_OP_W-1:0] CELL_PUSH_LO = 3'd2;
   localparam logic [CELL_OP_W-1:0] CELL_POP     = 3'd3;
   localparam logic [CELL_OP_W-1:0] CELL_RAISE   = 3'd4;
   localparam logic [CELL_OP_W-1:0] CELL_MARK    = 3'd5;
   localparam logic [CELL_OP_W-1:0] CELL_PROMOTE = 3'd6;
   localparam logic [CELL_OP_W-1:0] CELL_SORT    = 3'd7;

   // Command broadcast to every cell
   typedef struct packed {
      logic [CELL_OP_W-1:0] op;
   } cell_ctl_type;

   // Status a cell shows its neighbors and the controller
   typedef struct packed {
      logic valid;
      logic hi;
      logic match;
   } cell_stat_type;

endpackage

FILE: hdl/tcpqa_if.sv
// Request and response channel interfaces of the two-class priority queue.
interface tcpqa_req_if import tcpqa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [TICKET_W-1:0] ticket;
   logic                high_class;
   logic [TIME_W-1:0]   time_value;

   modport source (output valid, cmd, ticket, high_class, time_value, input ready);
   modport sink   (input valid, cmd, ticket, high_class, time_value, output ready);
endinterface

interface tcpqa_rsp_if import tcpqa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TICKET_W-1:0] out_ticket;
   logic                out_high;
   logic                out_urgent;
   logic [TIME_W-1:0]   out_arrival;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, out_ticket, out_high, out_urgent, out_arrival,
                   occupancy, input ready);
   modport sink   (input valid, status, out_ticket, out_high, out_urgent, out_arrival,
                   occupancy, output ready);
endinterface

FILE: hdl/two_class_priority_queue_aging.sv
// Top level: command sequencer and result register over a chain of queue cells.
//
//   port      dir  contents
//   req_bus   in   cmd, ticket, high_class, time_value  (valid/ready)
//   rsp_bus   out  status, out_ticket, out_high, out_urgent, out_arrival, occupancy
//   csr_*     in   age_limit write (csr_we, csr_wdata)
//
// Enqueue, dequeue and unused codes load the result on acceptance; emergency and
// remove of the entry at position p walk down the cells, then make adjacent swaps
// back to the head; a miss walks all count entries. Age makes one promote step,
// then DEPTH swap passes along the cell chain.
// Reset empties the queue and loads age_limit with 120. A stalled response
// holds the block: a new item is taken only when the result register is free.
module two_class_priority_queue_aging import tcpqa_pkg::*; #(
   parameter int DEPTH       = 16,
   parameter int TICKET_BITS = 16,
   parameter int TIME_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   tcpqa_req_if.sink        req_bus,
   tcpqa_rsp_if.source      rsp_bus,
   input  logic             csr_we,
   input  logic [AGE_W-1:0] csr_wdata
);

   localparam int CW = $clog2(DEPTH+1);
   localparam int IW = $clog2(DEPTH);
   localparam int EW = TICKET_BITS + TIME_BITS + 2;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SEEK    = 3'd1;
   localparam logic [2:0] ST_RAISE   = 3'd2;
   localparam logic [2:0] ST_PROMOTE = 3'd3;
   localparam logic [2:0] ST_SORT    = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          ptr_ff, ptr_in;
   logic [CMD_W-1:0]       cmd_ff;
   logic [TICKET_BITS-1:0] key_tkt_ff;
   logic [TIME_BITS-1:0]   key_time_ff;
   logic [AGE_W-1:0]       age_limit_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [TICKET_W-1:0]    out_ticket_ff;
   logic                   out_high_ff;
   logic                   out_urgent_ff;
   logic [TIME_W-1:0]      out_arrival_ff;
   logic [OCC_W-1:0]       occupancy_ff;

   logic                   accept;
   logic                   load_rsp;
   logic                   ret_en;
   logic [STATUS_W-1:0]    status_n;
   cell_ctl_type           ctl;
   logic [TICKET_BITS-1:0] cell_tkt;
   logic [TIME_BITS-1:0]   cell_time;
   logic                   hit;

   logic [EW-1:0]          ent [DEPTH];
   cell_stat_type          stat [DEPTH];
   logic [DEPTH-1:0]       match_vec;

   logic [TICKET_BITS-1:0] head_tkt;
   logic                   head_hi;
   logic                   head_urg;
   logic [TIME_BITS-1:0]   head_arr;

   // Handshake
   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   // Key fields go to the cells straight from the port while idle
   assign cell_tkt  = (state_ff == ST_IDLE) ? TICKET_BITS'(req_bus.ticket) : key_tkt_ff;
   assign cell_time = (state_ff == ST_IDLE) ? TIME_BITS'(req_bus.time_value) : key_time_ff;

   // Gather match bits and check the slot under the pointer
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_vec[i] = stat[i].match;
      end
   end
   assign hit = (ptr_ff < count_ff) && match_vec[ptr_ff[IW-1:0]];

   // Head entry
   assign head_tkt = ent[0][EW-1 -: TICKET_BITS];
   assign head_hi  = ent[0][TIME_BITS+1];
   assign head_urg = ent[0][TIME_BITS];
   assign head_arr = ent[0][TIME_BITS-1:0];

   // Sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      ctl.op   = CELL_HOLD;
      load_rsp = 1'b0;
      ret_en   = 1'b0;
      status_n = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_bus.cmd)
                  CMD_ENQUEUE: begin
                     load_rsp = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        status_n = STATUS_FULL;
                     end else begin
                        ctl.op   = req_bus.high_class ? CELL_PUSH_HI : CELL_PUSH_LO;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_DEQUEUE: begin
                     load_rsp = 1'b1;
                     if (count_ff == '0) begin
                        status_n = STATUS_EMPTY;
                     end else begin
                        ctl.op   = CELL_POP;
                        ret_en   = 1'b1;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  CMD_EMERGENCY, CMD_REMOVE: begin
                     ptr_in   = '0;
                     state_in = ST_SEEK;
                  end
                  CMD_AGE: begin
                     state_in = ST_PROMOTE;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_SEEK: begin
            if (ptr_ff == count_ff) begin
               load_rsp = 1'b1;
               status_n = STATUS_NOT_FOUND;
               state_in = ST_IDLE;
            end else if (hit) begin
               state_in = ST_RAISE;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end
         ST_RAISE: begin
            if (ptr_ff == '0) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
               if (cmd_ff == CMD_REMOVE) begin
                  ctl.op   = CELL_POP;
                  ret_en   = 1'b1;
                  count_in = count_ff - CW'(1);
               end else begin
                  ctl.op = CELL_MARK;
               end
            end else begin
               ctl.op = CELL_RAISE;
               ptr_in = ptr_ff - CW'(1);
            end
         end
         ST_PROMOTE: begin
            ctl.op   = CELL_PROMOTE;
            ptr_in   = '0;
            state_in = ST_SORT;
         end
         ST_SORT: begin
            ctl.op = CELL_SORT;
            if (ptr_ff == CW'(DEPTH - 1)) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         age_limit_ff <= AGE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         if (csr_we) begin
            age_limit_ff <= csr_wdata;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the item's command and keys for commands that pass through the sequencer states
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_bus.cmd;
         key_tkt_ff  <= TICKET_BITS'(req_bus.ticket);
         key_time_ff <= TIME_BITS'(req_bus.time_value);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         status_ff      <= status_n;
         out_ticket_ff  <= ret_en ? TICKET_W'(head_tkt) : '0;
         out_high_ff    <= ret_en && head_hi;
         out_urgent_ff  <= ret_en && head_urg;
         out_arrival_ff <= ret_en ? TIME_W'(head_arr) : '0;
         occupancy_ff   <= OCC_W'(count_in);
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.out_ticket  = out_ticket_ff;
   assign rsp_bus.out_high    = out_high_ff;
   assign rsp_bus.out_urgent  = out_urgent_ff;
   assign rsp_bus.out_arrival = out_arrival_ff;
   assign rsp_bus.occupancy   = occupancy_ff;

   // Cell chain, head at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_stat_type prev_stat;
      cell_stat_type next_stat;
      logic [EW-1:0] prev_ent;
      logic [EW-1:0] next_ent;

      if (i == 0) begin : g_head
         assign prev_stat = '{valid: 1'b1, hi: 1'b1, match: 1'b0};
         assign prev_ent  = '0;
      end else begin : g_mid
         assign prev_stat = stat[i-1];
         assign prev_ent  = ent[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_stat = '{valid: 1'b0, hi: 1'b0, match: 1'b0};
         assign next_ent  = '0;
      end else begin : g_body
         assign next_stat = stat[i+1];
         assign next_ent  = ent[i+1];
      end

      tcpqa_cell #(
         .DEPTH       (DEPTH),
         .TICKET_BITS (TICKET_BITS),
         .TIME_BITS   (TIME_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count_ff),
         .ptr       (ptr_ff),
         .key_tkt   (cell_tkt),
         .key_time  (cell_time),
         .age_limit (age_limit_ff),
         .prev_ent  (prev_ent),
         .prev_stat (prev_stat),
         .next_ent  (next_ent),
         .next_stat (next_stat),
         .ent_out   (ent[i]),
         .stat_out  (stat[i])
      );
   end

endmodule

FILE: hdl/tcpqa_cell.sv
// One queue slot: holds an entry and trades it with its neighbors.
module tcpqa_cell import tcpqa_pkg::*; #(
   parameter int DEPTH       = 16,
   parameter int TICKET_BITS = 16,
   parameter int TIME_BITS   = 16,
   parameter int INDEX       = 0
) (
   input  logic                                 clock,
   input  cell_ctl_type                         ctl,
   input  logic [$clog2(DEPTH+1)-1:0]           count,
   input  logic [$clog2(DEPTH+1)-1:0]           ptr,
   input  logic [TICKET_BITS-1:0]               key_tkt,
   input  logic [TIME_BITS-1:0]                 key_time,
   input  logic [AGE_W-1:0]                     age_limit,
   input  logic [TICKET_BITS+TIME_BITS+1:0]     prev_ent,
   input  cell_stat_type                        prev_stat,
   input  logic [TICKET_BITS+TIME_BITS+1:0]     next_ent,
   input  cell_stat_type                        next_stat,
   output logic [TICKET_BITS+TIME_BITS+1:0]     ent_out,
   output cell_stat_type                        stat_out
);

   localparam int CW     = $clog2(DEPTH+1);
   localparam int EW     = TICKET_BITS + TIME_BITS + 2;
   localparam int HI_BIT = TIME_BITS + 1;
   localparam int URG_BIT = TIME_BITS;
   localparam int CMPW   = (TIME_BITS > AGE_W) ? TIME_BITS : AGE_W;

   logic [EW-1:0]          ent_ff;
   logic [EW-1:0]          ent_in;
   logic [EW-1:0]          new_ent;
   logic                   my_valid;
   logic                   my_hi;
   logic [TICKET_BITS-1:0] my_tkt;
   logic [TIME_BITS-1:0]   my_arr;
   logic [TIME_BITS-1:0]   wait_t;
   logic                   aged;
   logic                   prev_hv;

   // Decode own slot
   assign my_valid = CW'(INDEX) < count;
   assign my_hi    = ent_ff[HI_BIT];
   assign my_tkt   = ent_ff[EW-1 -: TICKET_BITS];
   assign my_arr   = ent_ff[TIME_BITS-1:0];
   assign prev_hv  = prev_stat.valid & prev_stat.hi;
   assign new_ent  = {key_tkt, (ctl.op == CELL_PUSH_HI), 1'b0, key_time};

   // Wait beyond the limit, only for arrivals not in the future
   assign wait_t = key_time - my_arr;
   assign aged   = (key_time > my_arr) && (CMPW'(wait_t) > CMPW'(age_limit));

   // Select the next content of the slot
   always_comb begin
      ent_in = ent_ff;
      unique case (ctl.op)
         CELL_PUSH_HI: begin
            if (!(my_valid && my_hi)) begin
               ent_in = prev_hv ? new_ent : prev_ent;
            end
         end
         CELL_PUSH_LO: begin
            if (!my_valid && prev_stat.valid) begin
               ent_in = new_ent;
            end
         end
         CELL_POP: begin
            ent_in = next_ent;
         end
         CELL_RAISE: begin
            if (ptr == CW'(INDEX)) begin
               ent_in = prev_ent;
            end else if (ptr == CW'(INDEX + 1)) begin
               ent_in = next_ent;
            end
         end
         CELL_MARK: begin
            if (INDEX == 0) begin
               ent_in[HI_BIT]  = 1'b1;
               ent_in[URG_BIT] = 1'b1;
            end
         end
         CELL_PROMOTE: begin
            if (my_valid && !my_hi && aged) begin
               ent_in[HI_BIT] = 1'b1;
            end
         end
         CELL_SORT: begin
            // swap a high entry forward past a normal one
            if (my_valid && my_hi && prev_stat.valid && !prev_stat.hi) begin
               ent_in = prev_ent;
            end else if (my_valid && !my_hi && next_stat.valid && next_stat.hi) begin
               ent_in = next_ent;
            end
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent_out        = ent_ff;
   assign stat_out.valid = my_valid;
   assign stat_out.hi    = my_hi;
   assign stat_out.match = my_valid && (my_tkt == key_tkt);

endmodule

FILE: bench/tcpqa_checker.sv
// Checker: predicts each reply of the two-class priority queue and compares it with the block.
module tcpqa_checker import tcpqa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   tcpqa_req_if             req_bus,
   tcpqa_rsp_if             rsp_bus,
   input  logic             csr_we,
   input  logic [AGE_W-1:0] csr_wdata,
   output int unsigned      mismatches,
   output int unsigned      awaiting,
   output int unsigned      full_refusals,
   output int unsigned      empty_refusals,
   output int unsigned      ticket_misses,
   output int unsigned      promotions
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 16;

   typedef struct packed {
      logic [TICKET_W-1:0] ticket;
      logic                hi;
      logic                urgent;
      logic [TIME_W-1:0]   arrival;
   } ticket_entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      ticket_entry_type    entry;
      logic [OCC_W-1:0]    occupancy;
   } queue_reply_type;

   // Modeled queue, head first, and the replies still owed by the block
   ticket_entry_type line_up[$];
   queue_reply_type  replies_due[$];
   logic [AGE_W-1:0] age_limit;

   // Position of the entry nearest the head holding this ticket, or -1
   function automatic int locate(input logic [TICKET_W-1:0] ticket);
      foreach (line_up[i])
         if (line_up[i].ticket == ticket)
            return i;
      return -1;
   endfunction

   // Apply one command to the modeled queue and return the reply it should give
   function automatic queue_reply_type serve_command(input logic [CMD_W-1:0]    cmd,
                                                     input logic [TICKET_W-1:0] ticket,
                                                     input logic                high_class,
                                                     input logic [TIME_W-1:0]   time_value);
      queue_reply_type  reply;
      ticket_entry_type e;
      ticket_entry_type ahead[$];
      ticket_entry_type behind[$];
      int               pos;

      reply = '0;
      case (cmd)
         CMD_ENQUEUE: begin
            if (line_up.size() >= QUEUE_DEPTH) begin
               reply.status = STATUS_FULL;
               full_refusals++;
            end else begin
               // high entries go behind the leading run of high entries
               pos = 0;
               if (high_class) begin
                  while (pos < line_up.size() && line_up[pos].hi)
                     pos++;
               end else begin
                  pos = line_up.size();
               end
               e.ticket  = ticket;
               e.hi      = high_class;
               e.urgent  = 1'b0;
               e.arrival = time_value;
               line_up.insert(pos, e);
            end
         end
         CMD_DEQUEUE: begin
            if (line_up.size() == 0) begin
               reply.status = STATUS_EMPTY;
               empty_refusals++;
            end else begin
               reply.entry = line_up.pop_front();
            end
         end
         CMD_EMERGENCY: begin
            pos = locate(ticket);
            if (pos < 0) begin
               reply.status = STATUS_NOT_FOUND;
               ticket_misses++;
            end else begin
               // mark urgent and high, move to the front, keep the rest in order
               e = line_up[pos];
               line_up.delete(pos);
               e.hi     = 1'b1;
               e.urgent = 1'b1;
               line_up.push_front(e);
            end
         end
         CMD_REMOVE: begin
            pos = locate(ticket);
            if (pos < 0) begin
               reply.status = STATUS_NOT_FOUND;
               ticket_misses++;
            end else begin
               reply.entry = line_up[pos];
               line_up.delete(pos);
            end
         end
         CMD_AGE: begin
            // promote normal entries that waited too long, then split stably
            foreach (line_up[i]) begin
               e = line_up[i];
               if (!e.hi && time_value > e.arrival && time_value - e.arrival > age_limit) begin
                  e.hi = 1'b1;
                  promotions++;
               end
               if (e.hi)
                  ahead.push_back(e);
               else
                  behind.push_back(e);
            end
            line_up.delete();
            foreach (ahead[i])
               line_up.push_back(ahead[i]);
            foreach (behind[i])
               line_up.push_back(behind[i]);
         end
         default: begin
         end
      endcase
      reply.occupancy = OCC_W'(line_up.size());
      return reply;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         $display("%0d ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
         mismatches++;
      end
   endtask

   // Track the age limit, predict on each accepted item, compare each reply
   always @(posedge clock) begin : watch
      queue_reply_type seen;
      queue_reply_type want;

      if (reset) begin
         line_up.delete();
         replies_due.delete();
         age_limit = AGE_LIMIT_RESET;
      end else begin
         if (csr_we)
            age_limit = csr_wdata;
         if (req_bus.valid && req_bus.ready)
            replies_due.push_back(serve_command(req_bus.cmd, req_bus.ticket,
                                                req_bus.high_class, req_bus.time_value));
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status         = rsp_bus.status;
            seen.entry.ticket   = rsp_bus.out_ticket;
            seen.entry.hi       = rsp_bus.out_high;
            seen.entry.urgent   = rsp_bus.out_urgent;
            seen.entry.arrival  = rsp_bus.out_arrival;
            seen.occupancy      = rsp_bus.occupancy;
            if (replies_due.size() == 0) begin
               $display("%0d ns: unexpected reply, expected none, got status %0d ticket %0d",
                        $time, seen.status, seen.entry.ticket);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_field("status", 32'(want.status), 32'(seen.status));
               check_field("out_ticket", 32'(want.entry.ticket), 32'(seen.entry.ticket));
               check_field("out_high", 32'(want.entry.hi), 32'(seen.entry.hi));
               check_field("out_urgent", 32'(want.entry.urgent), 32'(seen.entry.urgent));
               check_field("out_arrival", 32'(want.entry.arrival),
                           32'(seen.entry.arrival));
               check_field("occupancy", 32'(want.occupancy), 32'(seen.occupancy));
            end
         end
      end
      awaiting <= replies_due.size();
   end

endmodule

FILE: bench/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the two-class priority queue.
module tb_top import tcpqa_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int               CYCLE_LIMIT      = 400000;
   localparam int               RANDOM_PHASES    = 6;
   localparam int               ITEMS_PER_PHASE  = 190;
   localparam int               SETTLE_CYCLES    = 40;
   localparam int               RECENT_SLOTS     = 16;
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [AGE_W-1:0] csr_wdata;

   int unsigned mismatches;
   int unsigned awaiting;
   int unsigned full_refusals;
   int unsigned empty_refusals;
   int unsigned ticket_misses;
   int unsigned promotions;
   int unsigned cycles;
   int unsigned items_sent;
   int unsigned unused_sent;
   int unsigned sent_by_cmd [8];

   // Tickets enqueued lately, so emergency and remove mostly hit
   bit [TICKET_W-1:0] recent [RECENT_SLOTS];
   int unsigned       recent_wr;
   logic [TIME_W-1:0] now;
   bit                steady;

   tcpqa_req_if req ();
   tcpqa_rsp_if rsp ();

   two_class_priority_queue_aging dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req),
      .rsp_bus   (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   tcpqa_checker reply_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req),
      .rsp_bus        (rsp),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .awaiting       (awaiting),
      .full_refusals  (full_refusals),
      .empty_refusals (empty_refusals),
      .ticket_misses  (ticket_misses),
      .promotions     (promotions)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one item after a random gap and hold it until accepted
   task automatic put_item(input logic [CMD_W-1:0]    cmd,
                           input logic [TICKET_W-1:0] ticket,
                           input logic                high_class,
                           input logic [TIME_W-1:0]   time_value);
      int gap;

      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.cmd        <= cmd;
      req.ticket     <= ticket;
      req.high_class <= high_class;
      req.time_value <= time_value;
      do @(posedge clock); while (!req.ready);
      items_sent++;
      sent_by_cmd[cmd]++;
      if (cmd >= CMD_UNUSED_FIRST)
         unused_sent++;
      if (cmd == CMD_ENQUEUE) begin
         recent[recent_wr] = ticket;
         recent_wr = (recent_wr + 1) % RECENT_SLOTS;
      end
   endtask

   // Drop valid and wait until every reply has come back
   task automatic settle();
      req.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic set_age_limit(input logic [AGE_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One random command, mostly well formed: known tickets, current time
   task automatic random_item(input int enq_weight);
      int                  roll;
      logic [CMD_W-1:0]    cmd;
      logic [TICKET_W-1:0] ticket;
      logic [TIME_W-1:0]   tv;

      roll   = $urandom_range(0, 99);
      now    = now + TIME_W'($urandom_range(0, 40));
      ticket = TICKET_W'($urandom);
      tv     = TIME_W'($urandom);
      if (roll < enq_weight) begin
         cmd = CMD_ENQUEUE;
         if ($urandom_range(0, 9) < 6)
            ticket = TICKET_W'($urandom_range(0, 47));
         if ($urandom_range(0, 9) < 8)
            tv = now;
      end else if (roll < enq_weight + 20) begin
         cmd = CMD_DEQUEUE;
      end else if (roll < enq_weight + 52) begin
         cmd = (roll < enq_weight + 35) ? CMD_EMERGENCY : CMD_REMOVE;
         if ($urandom_range(0, 3) != 0)
            ticket = recent[$urandom_range(0, RECENT_SLOTS - 1)];
         else if ($urandom_range(0, 1) == 0)
            ticket = TICKET_W'($urandom_range(0, 47));
      end else if (roll < 97) begin
         cmd = CMD_AGE;
         if ($urandom_range(0, 9) < 8)
            tv = now;
      end else begin
         cmd = CMD_UNUSED_FIRST
               + CMD_W'($urandom_range(0, CMD_UNUSED_LAST - CMD_UNUSED_FIRST));
      end
      put_item(cmd, ticket, $urandom_range(0, 2) == 0, tv);
   endtask

   // Take replies after a random stall
   initial begin : reply_side
      int stall;

      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   initial begin : stimulus
      logic [AGE_W-1:0] limit;
      int               enq_weight;

      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req.valid      <= 1'b0;
      req.cmd        <= CMD_ENQUEUE;
      req.ticket     <= '0;
      req.high_class <= 1'b0;
      req.time_value <= '0;
      now    = '0;
      steady = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: pop, misses, age, unused code
      put_item(CMD_DEQUEUE, 16'h0000, 1'b0, 16'h0000);
      put_item(CMD_REMOVE, 16'h0000, 1'b0, 16'h0000);
      put_item(CMD_EMERGENCY, 16'hFFFF, 1'b1, 16'hFFFF);
      put_item(CMD_AGE, 16'hFFFF, 1'b1, 16'hFFFF);
      put_item(CMD_UNUSED_LAST, 16'hFFFF, 1'b1, 16'hFFFF);

      // Duplicate tickets, arrival in the future, age at the default limit
      put_item(CMD_ENQUEUE, 16'hFFFF, 1'b0, 16'h0000);
      put_item(CMD_ENQUEUE, 16'h0000, 1'b1, 16'hFFFF);
      put_item(CMD_ENQUEUE, 16'hFFFF, 1'b1, 16'd100);
      put_item(CMD_EMERGENCY, 16'hFFFF, 1'b0, 16'h0000);
      put_item(CMD_AGE, 16'h0000, 1'b0, 16'd120);
      put_item(CMD_AGE, 16'h0000, 1'b0, 16'd121);
      put_item(CMD_DEQUEUE, 16'h0000, 1'b0, 16'h0000);
      put_item(CMD_REMOVE, 16'hFFFF, 1'b0, 16'h0000);

      // Fill to the brim, overflow, then reach the deepest slots
      for (int i = 0; i < 15; i++)
         put_item(CMD_ENQUEUE, TICKET_W'(1000 + i), i[0], TIME_W'(200 + i));
      put_item(CMD_ENQUEUE, 16'd2000, 1'b1, 16'd300);
      put_item(CMD_EMERGENCY, 16'd1012, 1'b0, 16'h0000);
      put_item(CMD_REMOVE, 16'd1014, 1'b0, 16'h0000);

      // Random phases, each under its own age limit and command mix
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: limit = '0;
            1: limit = '1;
            2: limit = AGE_W'($urandom_range(0, 400));
            3: limit = 16'd1;
            4: limit = AGE_W'($urandom);
            default: limit = AGE_LIMIT_RESET;
         endcase
         enq_weight = (phase % 3 == 1) ? 44 : ((phase % 3 == 2) ? 22 : 34);
         set_age_limit(limit);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0)
               steady = ($urandom_range(0, 3) == 0);
            random_item(enq_weight);
         end
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items (enq %0d, deq %0d, emerg %0d, remove %0d, age %0d, unused %0d)",
               items_sent, sent_by_cmd[CMD_ENQUEUE], sent_by_cmd[CMD_DEQUEUE],
               sent_by_cmd[CMD_EMERGENCY], sent_by_cmd[CMD_REMOVE], sent_by_cmd[CMD_AGE],
               unused_sent);
      $display("Saw %0d full refusals, %0d empty pops, %0d ticket misses, %0d promotions",
               full_refusals, empty_refusals, ticket_misses, promotions);
      if (mismatches == 0 && awaiting == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
